@@ rtl/core/mjpd_pkg.sv @@
// Package for the multi-joint PD servo: beat structs, command codes, sizes.
// Used by rtl/core/multi_joint_pd_servo.sv; depends on nothing else.
package mjpd_pkg;

  // Number of joints served; joint index field is 5 bits wide
  localparam int JOINTS = 32;
  localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int JOINT_W = 5;
  localparam int DATA_W  = 32;
  localparam int RATE_W  = 17;

  // Loop rate after reset, in Hz
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEED   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GAIN   = 2'd2;

  // Input beat
  typedef struct packed {
    logic        [CMD_W-1:0]   cmd;
    logic        [JOINT_W-1:0] joint;
    logic signed [DATA_W-1:0]  q_act;
    logic signed [DATA_W-1:0]  q_ref;
    logic signed [DATA_W-1:0]  p_gain;
    logic signed [DATA_W-1:0]  d_gain;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic        [JOINT_W-1:0] joint_out;
    logic signed [DATA_W-1:0]  torque;
    logic                      saturated;
  } out_item_t;

endpackage

@@ rtl/core/multi_joint_pd_servo.sv @@
// Multi-joint PD servo: per-joint position/gain storage and a shared multiplier.
// Depends on mjpd_pkg (beat structs, command codes, sizes).
// Sample beat: busy through S_DV, S_VEL, S_PT and S_DT (three products through one
//   33x33 multiplier, then add and clamp); result and strobe register from S_DT.
//   Seed and gain beats are written on the accepting edge, busy never raised.
// No new beat is accepted while busy; the receiver cannot stall the result.
// Reset (rst_n low, synchronous): sequencer idle, strobe low, rate = 1000 Hz;
//   position and gain storage is not cleared.
module multi_joint_pd_servo (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  mjpd_pkg::in_item_t                   in_item,
  // result channel
  output logic                                 out_strobe,
  output mjpd_pkg::out_item_t                  out_item,
  // configuration
  input  logic                                 cfg_we,
  input  logic [mjpd_pkg::RATE_W-1:0]          cfg_wdata
);

  localparam int DW = mjpd_pkg::DATA_W;
  localparam int MW = DW + 1;          // multiplier operand width
  localparam int PW = 2 * MW;          // product width

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DV   = 5'b00010,
    S_VEL  = 5'b00100,
    S_PT   = 5'b01000,
    S_DT   = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [mjpd_pkg::RATE_W-1:0]    rate_r;
  mjpd_pkg::in_item_t             item_r;

  // storage: {actual, reference} and {kp, kd} per joint
  logic [2*DW-1:0]                prev_mem_r [mjpd_pkg::JOINTS];
  logic [2*DW-1:0]                gain_mem_r [mjpd_pkg::JOINTS];
  logic [2*DW-1:0]                prev_rd_r, gain_rd_r;

  logic                           accept, in_range;
  logic                           prev_we;
  logic [mjpd_pkg::JIDX_W-1:0]    prev_widx;
  logic [2*DW-1:0]                prev_wdata;

  logic signed [MW-1:0]           mul_a, mul_b;
  logic signed [PW-1:0]           mul_p, prod_r;

  logic signed [DW-1:0]           pact, pref, kp, kd;
  logic signed [DW+2:0]           dv;
  logic signed [MW-1:0]           dv_c;
  logic signed [MW-1:0]           err_r;
  logic signed [DW-1:0]           vel_r, vel_nxt;
  logic                           vsat_r, vsat_nxt;
  logic signed [PW-17:0]          pterm_r;
  logic signed [PW-17:0]          sum;
  logic signed [DW-1:0]           tau;
  logic                           tsat;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(in_item.joint) < mjpd_pkg::JOINTS);

  assign pact = prev_rd_r[2*DW-1:DW];
  assign pref = prev_rd_r[DW-1:0];
  assign kp   = gain_rd_r[2*DW-1:DW];
  assign kd   = gain_rd_r[DW-1:0];

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= mjpd_pkg::RATE_RESET;
    end else if (cfg_we) begin
      rate_r <= cfg_wdata;
    end
  end

  // position store write: seed on accept, or sample update in S_DV
  always_comb begin
    prev_we    = 1'b0;
    prev_widx  = item_r.joint[mjpd_pkg::JIDX_W-1:0];
    prev_wdata = {item_r.q_act, item_r.q_ref};
    if (accept && in_range && in_item.cmd == mjpd_pkg::CMD_SEED) begin
      prev_we    = 1'b1;
      prev_widx  = in_item.joint[mjpd_pkg::JIDX_W-1:0];
      prev_wdata = {in_item.q_act, in_item.q_act};
    end else if (state_r == S_DV) begin
      prev_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem_r[prev_widx] <= prev_wdata;
    end
    if (accept) begin
      prev_rd_r <= prev_mem_r[in_item.joint[mjpd_pkg::JIDX_W-1:0]];
    end
  end

  // gain store
  always_ff @(posedge clk) begin
    if (accept && in_range && in_item.cmd == mjpd_pkg::CMD_GAIN) begin
      gain_mem_r[in_item.joint[mjpd_pkg::JIDX_W-1:0]] <= {in_item.p_gain, in_item.d_gain};
    end
    if (accept) begin
      gain_rd_r <= gain_mem_r[in_item.joint[mjpd_pkg::JIDX_W-1:0]];
    end
  end

  // latch the beat
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  // position delta; beyond 33 bits the product saturates anyway (or is zero)
  always_comb begin
    dv = ((35'(item_r.q_ref) - 35'(pref)) - (35'(item_r.q_act) - 35'(pact)));
    if (dv[DW+2:DW] == 3'b000 || dv[DW+2:DW] == 3'b111) begin
      dv_c = dv[MW-1:0];
    end else if (dv[DW+2]) begin
      dv_c = {1'b1, {DW{1'b0}}};
    end else begin
      dv_c = {1'b0, {DW{1'b1}}};
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DV: begin
        mul_a = dv_c;
        mul_b = MW'(rate_r);
      end
      S_VEL: begin
        mul_a = err_r;
        mul_b = MW'(kp);
      end
      S_PT: begin
        mul_a = MW'(vel_r);
        mul_b = MW'(kd);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // velocity saturation from the rate product
  always_comb begin
    if (prod_r[PW-1:DW-1] == '0 || prod_r[PW-1:DW-1] == '1) begin
      vel_nxt  = prod_r[DW-1:0];
      vsat_nxt = 1'b0;
    end else begin
      vel_nxt  = prod_r[PW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      vsat_nxt = 1'b1;
    end
  end

  // final sum of floor-shifted terms and saturation
  always_comb begin
    sum = pterm_r + prod_r[PW-1:16];
    if (sum[PW-17:DW-1] == '0 || sum[PW-17:DW-1] == '1) begin
      tau  = sum[DW-1:0];
      tsat = 1'b0;
    end else begin
      tau  = sum[PW-17] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      tsat = 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (state_r == S_DV) begin
      err_r <= MW'(item_r.q_ref) - MW'(item_r.q_act);
    end
    if (state_r == S_VEL) begin
      vel_r  <= vel_nxt;
      vsat_r <= vsat_nxt;
    end
    if (state_r == S_PT) begin
      pterm_r <= prod_r[PW-1:16];
    end
    if (state_r == S_DT) begin
      out_item.joint_out <= item_r.joint;
      out_item.torque    <= tau;
      out_item.saturated <= tsat || vsat_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_range && in_item.cmd == mjpd_pkg::CMD_SAMPLE) begin
          state_nxt = S_DV;
        end
      end
      S_DV:    state_nxt = S_VEL;
      S_VEL:   state_nxt = S_PT;
      S_PT:    state_nxt = S_DT;
      S_DT:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= (state_r == S_DT);
    end
  end

  // checks
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == S_DT)
    else $error("result strobe without a finished sample");

  a_dt_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DT |=> out_strobe && !busy)
    else $error("finished sample did not deliver its result");

  a_seed_gain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.cmd != mjpd_pkg::CMD_SAMPLE |=> !busy)
    else $error("non-sample beat started the sequencer");

  a_sample_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_range && in_item.cmd == mjpd_pkg::CMD_SAMPLE |=> state_r == S_DV)
    else $error("sample beat did not start the sequencer");

endmodule

@@ tb/sv/tb_multi_joint_pd_servo.sv @@
// Self-checking testbench for multi_joint_pd_servo: directed and random command beats,
// with a scoreboard that predicts each torque beat from its own copy of joint state.
// Depends on mjpd_pkg and rtl/core/multi_joint_pd_servo.sv.
module tb_multi_joint_pd_servo;

  // Spare command code; the block drops it without a result
  localparam logic [mjpd_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int STALL_LIMIT    = 2000;  // cycles without any beat moving
  localparam int RAND_PER_PHASE = 48;
  localparam int MAX_REPORTS    = 10;

  localparam longint Q_MAX = (longint'(1) <<< 31) - 1;
  localparam longint Q_MIN = -(longint'(1) <<< 31);

  // Torque predictor and expected-beat queue
  class servo_scoreboard;
    logic signed [mjpd_pkg::DATA_W-1:0] last_meas[mjpd_pkg::JOINTS];
    logic signed [mjpd_pkg::DATA_W-1:0] last_cmd[mjpd_pkg::JOINTS];
    logic signed [mjpd_pkg::DATA_W-1:0] kp_tab[mjpd_pkg::JOINTS];
    logic signed [mjpd_pkg::DATA_W-1:0] kd_tab[mjpd_pkg::JOINTS];
    logic [mjpd_pkg::RATE_W-1:0]        rate_hz;
    mjpd_pkg::out_item_t                torque_q[$];
    int unsigned                        mismatches;

    function new();
      rate_hz    = mjpd_pkg::RATE_RESET;
      mismatches = 0;
    endfunction

    function void set_rate(logic [mjpd_pkg::RATE_W-1:0] r);
      rate_hz = r;
    endfunction

    function int pending();
      return torque_q.size();
    endfunction

    function longint clamp32(longint x, inout bit hit);
      if (x > Q_MAX) begin
        hit = 1'b1;
        return Q_MAX;
      end
      if (x < Q_MIN) begin
        hit = 1'b1;
        return Q_MIN;
      end
      return x;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Update joint state for an accepted beat; queue the torque for a sample
    function void note_beat(mjpd_pkg::in_item_t b);
      longint              meas, cmd_pos, err, vel, p_term, d_term, tau;
      bit                  hit;
      int                  j;
      mjpd_pkg::out_item_t want;
      hit = 1'b0;
      j   = int'(b.joint);
      if (j >= mjpd_pkg::JOINTS) return;
      case (b.cmd)
        mjpd_pkg::CMD_SEED: begin
          last_meas[j] = b.q_act;
          last_cmd[j]  = b.q_act;
        end
        mjpd_pkg::CMD_GAIN: begin
          kp_tab[j] = b.p_gain;
          kd_tab[j] = b.d_gain;
        end
        mjpd_pkg::CMD_SAMPLE: begin
          meas    = $signed(b.q_act);
          cmd_pos = $signed(b.q_ref);
          err     = cmd_pos - meas;
          vel     = (cmd_pos - longint'(last_cmd[j])) - (meas - longint'(last_meas[j]));
          vel     = clamp32(vel * longint'(rate_hz), hit);
          // Q32.32 products back to Q16.16, floor rounding
          p_term  = (longint'(kp_tab[j]) * err) >>> 16;
          d_term  = (longint'(kd_tab[j]) * vel) >>> 16;
          tau     = clamp32(p_term + d_term, hit);
          last_meas[j]   = b.q_act;
          last_cmd[j]    = b.q_ref;
          want.joint_out = b.joint;
          want.torque    = tau[31:0];
          want.saturated = hit;
          torque_q.push_back(want);
        end
        default: ;
      endcase
    endfunction

    // Compare a result beat with the oldest expected torque
    function void check_result(mjpd_pkg::out_item_t got);
      mjpd_pkg::out_item_t want;
      if (torque_q.size() == 0) begin
        report($sformatf("unexpected result beat: joint %0d torque %0d sat %0b",
                         got.joint_out, got.torque, got.saturated));
        return;
      end
      want = torque_q.pop_front();
      if (got.joint_out !== want.joint_out || got.torque !== want.torque ||
          got.saturated !== want.saturated)
        report($sformatf({"torque mismatch: expected joint %0d torque %0d sat %0b,",
                          " got joint %0d torque %0d sat %0b"},
                         want.joint_out, want.torque, want.saturated,
                         got.joint_out, got.torque, got.saturated));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  mjpd_pkg::in_item_t            in_item;
  logic                          out_strobe;
  mjpd_pkg::out_item_t           out_item;
  logic                          cfg_we;
  logic [mjpd_pkg::RATE_W-1:0]   cfg_wdata;

  servo_scoreboard     board;
  bit                  pos_ready[mjpd_pkg::JOINTS];
  bit                  gain_ready[mjpd_pkg::JOINTS];
  int                  burst_left;
  int                  stall_cycles;

  multi_joint_pd_servo dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) board.check_result(out_item);
  end

  // Watchdog: no beat moving in either direction for too long
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_multi_joint_pd_servo NOT OK");
        $finish;
      end
    end
  end

  // Mix of extremes, full-range words and small Q16.16 values
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom();
      5, 6:    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      default: return 32'($urandom_range(0, 32'h0000_2000)) - 32'h0000_1000;
    endcase
  endfunction

  // Sender gap: random idle time before a beat, with occasional back-to-back bursts
  function automatic int pick_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(5, 15);
    return $urandom_range(0, 19);
  endfunction

  // Drive one command beat and wait for it to be taken
  task automatic issue(logic [mjpd_pkg::CMD_W-1:0] cmd, int j, logic [31:0] act,
                       logic [31:0] pos_ref, logic [31:0] kp, logic [31:0] kd);
    mjpd_pkg::in_item_t b;
    int                 gap;
    b.cmd    = cmd;
    b.joint  = j[mjpd_pkg::JOINT_W-1:0];
    b.q_act  = act;
    b.q_ref  = pos_ref;
    b.p_gain = kp;
    b.d_gain = kd;
    gap      = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= b;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_beat(b);
    if (cmd == mjpd_pkg::CMD_SEED || cmd == mjpd_pkg::CMD_SAMPLE) pos_ready[j] = 1'b1;
    if (cmd == mjpd_pkg::CMD_GAIN) gain_ready[j] = 1'b1;
  endtask

  // Random beat; joints are set up before any sample reads them
  task automatic random_beat(output bit counted);
    int j, roll;
    j       = ($urandom_range(0, 3) == 0) ? $urandom_range(0, mjpd_pkg::JOINTS - 1)
                                          : $urandom_range(0, 7);
    roll    = $urandom_range(0, 99);
    counted = 1'b1;
    if (!gain_ready[j]) begin
      issue(mjpd_pkg::CMD_GAIN, j, rand_word(), rand_word(), rand_word(), rand_word());
    end else if (!pos_ready[j]) begin
      issue(mjpd_pkg::CMD_SEED, j, rand_word(), rand_word(), rand_word(), rand_word());
    end else if (roll < 62) begin
      issue(mjpd_pkg::CMD_SAMPLE, j, rand_word(), rand_word(), rand_word(), rand_word());
    end else if (roll < 76) begin
      issue(mjpd_pkg::CMD_SEED, j, rand_word(), rand_word(), rand_word(), rand_word());
    end else if (roll < 93) begin
      issue(mjpd_pkg::CMD_GAIN, j, rand_word(), rand_word(), rand_word(), rand_word());
    end else begin
      issue(CMD_NONE, j, rand_word(), rand_word(), rand_word(), rand_word());
      counted = 1'b0;
    end
  endtask

  // Stop sending and let all outstanding torque beats arrive
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Rate register write, only with the block idle
  task automatic write_rate(logic [mjpd_pkg::RATE_W-1:0] r);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_rate(r);
  endtask

  initial begin
    int unsigned rate_plan[5];
    int          done_items;
    bit          counted;
    rate_plan    = '{0, 1, 100000, 131071, 1000};
    board        = new();
    burst_left   = 0;
    stall_cycles = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset rate
    issue(mjpd_pkg::CMD_GAIN, 0, rand_word(), rand_word(), 32'h0001_0000, 32'h0000_0100);
    issue(mjpd_pkg::CMD_SEED, 0, 32'h0000_0000, rand_word(), rand_word(), rand_word());
    issue(mjpd_pkg::CMD_SAMPLE, 0, 32'h0000_1000, 32'h0000_2000, rand_word(), rand_word());
    // zero error, derivative term only
    issue(mjpd_pkg::CMD_SAMPLE, 0, 32'h0000_2000, 32'h0000_2000, rand_word(), rand_word());
    issue(mjpd_pkg::CMD_GAIN, 31, rand_word(), rand_word(), 32'h7FFF_FFFF, 32'h8000_0000);
    issue(mjpd_pkg::CMD_SEED, 31, 32'h7FFF_FFFF, rand_word(), rand_word(), rand_word());
    // full-scale swings: velocity and torque both clamp
    issue(mjpd_pkg::CMD_SAMPLE, 31, 32'h8000_0000, 32'h7FFF_FFFF, rand_word(), rand_word());
    issue(mjpd_pkg::CMD_SAMPLE, 31, 32'h7FFF_FFFF, 32'h8000_0000, rand_word(), rand_word());
    issue(mjpd_pkg::CMD_GAIN, 1, rand_word(), rand_word(), 32'h8000_0000, 32'h7FFF_FFFF);
    issue(mjpd_pkg::CMD_SEED, 1, 32'h8000_0000, rand_word(), rand_word(), rand_word());
    issue(mjpd_pkg::CMD_SAMPLE, 1, 32'h7FFF_FFFF, 32'h8000_0000, rand_word(), rand_word());
    issue(mjpd_pkg::CMD_SAMPLE, 1, 32'h8000_0000, 32'h8000_0000, rand_word(), rand_word());
    // zero gains
    issue(mjpd_pkg::CMD_GAIN, 2, rand_word(), rand_word(), 32'h0000_0000, 32'h0000_0000);
    issue(mjpd_pkg::CMD_SEED, 2, 32'hFFFF_FFFF, rand_word(), rand_word(), rand_word());
    issue(mjpd_pkg::CMD_SAMPLE, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rand_word(), rand_word());
    // smallest negative gains: floor rounding of tiny negative products
    issue(mjpd_pkg::CMD_GAIN, 2, rand_word(), rand_word(), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(mjpd_pkg::CMD_SAMPLE, 2, 32'h0000_0000, 32'h0000_0001, rand_word(), rand_word());
    // spare command code is dropped
    issue(CMD_NONE, 3, rand_word(), rand_word(), rand_word(), rand_word());
    issue(CMD_NONE, 0, rand_word(), rand_word(), rand_word(), rand_word());
    issue(mjpd_pkg::CMD_SAMPLE, 0, 32'hFFFF_0000, 32'h0001_0000, rand_word(), rand_word());

    // Random phases, each under its own loop rate (zero and the extremes first)
    for (int ph = 0; ph < 8; ph++) begin
      write_rate(mjpd_pkg::RATE_W'((ph < 5) ? rate_plan[ph] : $urandom_range(1, 100000)));
      done_items = 0;
      while (done_items < RAND_PER_PHASE) begin
        random_beat(counted);
        if (counted) done_items++;
      end
    end

    drain();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_multi_joint_pd_servo OK");
    end else begin
      $display("tb_multi_joint_pd_servo NOT OK");
    end
    $finish;
  end

endmodule
